@@ hdl/bounded_value_list_defines.svh @@
// assertion macros for the bounded value list checker
`ifndef BOUNDED_VALUE_LIST_DEFINES_SVH
`define BOUNDED_VALUE_LIST_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BVL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define BVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bvl_pkg.sv @@
// shared constants, types and helpers of the bounded value list
package bvl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int VAL_W      = 32;

    localparam logic [2:0] CMD_APPEND    = 3'd0;
    localparam logic [2:0] CMD_PUSH_HEAD = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_REMOVE    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    // physical slot of a logical position in the ring
    function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W-1:0] s;
        s = CNT_W'(base) + off;
        if (s >= DEPTH_C)
            s = s - DEPTH_C;
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [4:0] count5(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[4:0];
    endfunction

endpackage

@@ hdl/bounded_value_list.sv @@
// top level of the bounded value list: sequencer plus cell memory
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  s_axis   | in  | item_value[31:0]                   | cmd[2:0]
//  m_axis   | out | removed_value[31:0], entry_count   | status[1:0]
//
// append and insert head write the cell on accept; remove head and remove
// tail read the cell and wait for its data; remove by value scans from the
// head, then shifts the cells after the match down one, all through the
// single read port of the cell memory. one command is in flight at a time;
// a new one is taken while the previous result waits in the output
// register. reset clears head pointer and count, not the cell contents.
module bounded_value_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // item_value[31:0]
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // removed_value[31:0], entry_count[36:32], zero
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import bvl_pkg::*;

    mem_req_t         mem_req;
    logic [VAL_W-1:0] mem_rdata;
    logic [VAL_W-1:0] removed;
    logic [4:0]       count;

    bvl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_cmd     (s_axis_tuser),
        .s_val     (s_axis_tdata),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_status  (m_axis_tuser),
        .m_removed (removed),
        .m_count   (count),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bvl_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (IDX_W),
        .DW    (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign m_axis_tdata = {3'b000, count, removed};

endmodule

@@ hdl/bvl_ram.sv @@
// generic single-write single-read ram with registered read data
module bvl_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bvl_ctrl.sv @@
// command sequencer: ring pointers, scan and shift over the cell memory
module bvl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2:0]              s_cmd,
    input  logic [bvl_pkg::VAL_W-1:0] s_val,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [1:0]              m_status,
    output logic [bvl_pkg::VAL_W-1:0] m_removed,
    output logic [4:0]              m_count,
    output bvl_pkg::mem_req_t       mem_req,
    input  logic [bvl_pkg::VAL_W-1:0] mem_rdata
);
    import bvl_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_POP_WAIT, S_SCAN, S_SHIFT, S_DONE} state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [1:0]       st_reg, st_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [VAL_W-1:0] m_removed_reg, m_removed_next;
    logic [4:0]       m_count_reg, m_count_next;
    logic [CNT_W-1:0] last_pos;
    logic [IDX_W-1:0] head_dec;

    assign last_pos = count_reg - CNT_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_W'(LIST_DEPTH - 1) : head_reg - IDX_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        rem_next       = rem_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_status_next  = m_status_reg;
        m_removed_next = m_removed_reg;
        m_count_next   = m_count_reg;
        mem_req        = '0;
        s_tready       = (state_reg == S_IDLE);

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_cmd;
                    val_next   = s_val;
                    st_next    = ST_OK;
                    rem_next   = '0;
                    pos_next   = '0;
                    state_next = S_DONE;
                    case (s_cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg >= DEPTH_C)
                                st_next = ST_FULL;
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ring_idx(head_reg, count_reg);
                                mem_req.wdata = s_val;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_HEAD:
                        begin
                            if (count_reg >= DEPTH_C)
                                st_next = ST_FULL;
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = head_dec;
                                mem_req.wdata = s_val;
                                head_next     = head_dec;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_HEAD, CMD_POP_TAIL:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                mem_req.raddr = (s_cmd == CMD_POP_HEAD) ? head_reg
                                              : ring_idx(head_reg, last_pos);
                                state_next = S_POP_WAIT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                mem_req.raddr = head_reg;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                rem_next   = mem_rdata;
                count_next = last_pos;
                if (cmd_reg == CMD_POP_HEAD)
                    head_next = ring_idx(head_reg, CNT_W'(1));
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // read data is the cell at pos_reg
                if (mem_rdata == val_reg)
                begin
                    rem_next = mem_rdata;
                    if (pos_reg == last_pos)
                    begin
                        count_next = last_pos;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_req.raddr = ring_idx(head_reg, pos_reg + CNT_W'(1));
                        state_next    = S_SHIFT;
                    end
                end
                else if (pos_reg == last_pos)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next      = pos_reg + CNT_W'(1);
                    mem_req.raddr = ring_idx(head_reg, pos_reg + CNT_W'(1));
                end
            end
            S_SHIFT:
            begin
                // read data is the cell after pos_reg, move it down one
                mem_req.we    = 1'b1;
                mem_req.waddr = ring_idx(head_reg, pos_reg);
                mem_req.wdata = mem_rdata;
                pos_next      = pos_reg + CNT_W'(1);
                if (pos_reg + CNT_W'(1) == last_pos)
                begin
                    count_next = last_pos;
                    state_next = S_DONE;
                end
                else
                    mem_req.raddr = ring_idx(head_reg, pos_reg + CNT_W'(2));
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    m_status_next  = st_reg;
                    m_removed_next = rem_reg;
                    m_count_next   = count5(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
        rem_reg       <= rem_next;
        m_status_reg  <= m_status_next;
        m_removed_reg <= m_removed_next;
        m_count_reg   <= m_count_next;
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_status  = m_status_reg;
    assign m_removed = m_removed_reg;
    assign m_count   = m_count_reg;

endmodule

@@ hdl/bvl_checker.sv @@
// port-level checks of the bounded value list, bound to the top level
`include "bounded_value_list_defines.svh"

module bvl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import bvl_pkg::*;

    logic out_beat_hold;
    logic in_beat_taken;
    assign out_beat_hold = m_axis_tvalid && !m_axis_tready;
    assign in_beat_taken = s_axis_tvalid && s_axis_tready;

    `BVL_ASSERT_NEXT(a_out_hold, out_beat_hold, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")
    `BVL_ASSERT_NEXT(a_one_in_flight, in_beat_taken, !s_axis_tready, "command taken while another is in flight")
    `BVL_ASSERT_NOW(a_fail_no_value, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[31:0] == 32'd0, "failed command reports a value")
    `BVL_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[36:32] == count5(DEPTH_C), "full status with list not full")
    `BVL_ASSERT_NOW(a_empty_count, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata[36:32] == 5'd0, "empty status with entries held")

endmodule

bind bounded_value_list bvl_checker u_bvl_checker (.*);
